### rtl/lstwp_pkg.sv
// Package for the lidar scan to world point block: beat types, register codes,
// CORDIC constants and arctangent table. No dependencies.
`timescale 1ns / 1ps
package lstwp_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int Q_DEPTH           = 2;
  localparam int XW                = 36;
  localparam int ZW                = 34;
  localparam int RW                = XW - 16;
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam logic [9:0]  DECIMATION_RST = 10'd50;

  typedef enum logic [2:0] {
    REG_SCAN_START   = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_RANGE_LOW    = 3'd2,
    REG_RANGE_HIGH   = 3'd3,
    REG_POSE_X       = 3'd4,
    REG_POSE_Y       = 3'd5,
    REG_POSE_HEADING = 3'd6,
    REG_DECIMATION   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ITER,
    ST_ROUND,
    ST_ADD,
    ST_HOLD
  } back_state_e;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        scan_first;
  } pt_in_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [15:0]        point_index;
  } pt_out_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] theta;
    logic [15:0] index;
  } pt_job_t;

  typedef struct packed {
    logic [15:0]        scan_start_angle;
    logic [15:0]        angle_step;
    logic [15:0]        range_low;
    logic [15:0]        range_high;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;
    logic [9:0]         decimation;
  } lstwp_cfg_t;

  localparam lstwp_cfg_t CFG_RST = '{
    scan_start_angle: 16'd0, angle_step: 16'd0, range_low: 16'd0, range_high: 16'hFFFF,
    pose_x: 32'sd0, pose_y: 32'sd0, pose_heading: 16'd0, decimation: DECIMATION_RST
  };

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

### rtl/lstwp_front.sv
// Front end: accepts sample beats, tracks beam angle, index and decimation phase,
// and forwards qualifying samples as jobs. Depends on lstwp_pkg.
`timescale 1ns / 1ps
module lstwp_front import lstwp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lstwp_cfg_t cfg_i,
  input  logic       take_i,
  input  pt_in_t     item_i,
  output logic       job_push_o,
  output pt_job_t    job_o
);

  logic [15:0] angle_q, angle_d, count_q, count_d, ang_cur, cnt_cur;
  logic [9:0]  phase_q, phase_d, ph_cur, dec;
  logic [10:0] ph_next;

  always_comb begin
    ang_cur = item_i.scan_first ? cfg_i.scan_start_angle : angle_q;
    cnt_cur = item_i.scan_first ? 16'd0 : count_q;
    ph_cur  = item_i.scan_first ? 10'd0 : phase_q;
    dec     = (cfg_i.decimation == 10'd0) ? 10'd1 : cfg_i.decimation;
    ph_next = {1'b0, ph_cur} + 11'd1;
    angle_d = ang_cur + cfg_i.angle_step;
    count_d = cnt_cur + 16'd1;
    phase_d = (ph_next >= {1'b0, dec}) ? 10'd0 : ph_next[9:0];
    job_push_o = take_i && (item_i.range_mm > cfg_i.range_low) &&
                 (item_i.range_mm < cfg_i.range_high) && (ph_cur == 10'd0);
    job_o.range_mm = item_i.range_mm;
    job_o.theta    = ang_cur + cfg_i.pose_heading;
    job_o.index    = cnt_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      count_q <= '0;
      phase_q <= '0;
    end else if (take_i) begin
      angle_q <= angle_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

endmodule

### rtl/lstwp_queue.sv
// Short job queue between front and back end.
// Depends on lstwp_pkg.
`timescale 1ns / 1ps
module lstwp_queue import lstwp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pt_job_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output pt_job_t data_o
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  pt_job_t mem_q [Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

### rtl/lstwp_back.sv
// Back end: gain multiply, quadrant fold, iterative CORDIC rotation, rounding,
// pose offset with saturation and result register. Depends on lstwp_pkg.
`timescale 1ns / 1ps
module lstwp_back import lstwp_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lstwp_cfg_t cfg_i,
  input  logic       job_valid_i,
  input  pt_job_t    job_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  output pt_out_t    out_o,
  input  logic       out_pop_i
);

  localparam logic [31:0] PMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [4:0]  LAST  = 5'(CORDIC_STAGES - 1);

  back_state_e state_q, state_d;
  pt_job_t     job_q;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic [4:0]  iter_q, iter_d;
  logic signed [RW-1:0] rx_q, ry_q, rx_d, ry_d;
  logic [47:0] prod;
  logic [31:0] phase;
  logic        fold, out_valid_q, out_load;
  pt_out_t     out_q, out_d;
  logic signed [33:0] sx, sy;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    iter_d    = iter_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    prod      = 48'(job_q.range_mm) * 48'(GAIN_Q32);
    phase     = {job_q.theta, 16'd0} & PMASK;
    fold      = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    xs        = x_q >>> iter_q;
    ys        = y_q >>> iter_q;
    at        = ZW'(atan_turns(iter_q));
    sx        = 34'(cfg_i.pose_x) + 34'(rx_q);
    sy        = 34'(cfg_i.pose_y) + 34'(ry_q);
    out_d.world_x     = sat(sx);
    out_d.world_y     = sat(sy);
    out_d.point_index = job_q.index;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        x_d    = fold ? -$signed({4'd0, prod[47:16]}) : $signed({4'd0, prod[47:16]});
        y_d    = '0;
        z_d    = ZW'($signed({phase[31] ^ fold, phase[30:0]}));
        iter_d = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        iter_d = iter_q + 5'd1;
        if (iter_q == LAST) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        rx_d = RW'((x_q + XW'(32768)) >>> 16);
        ry_d = RW'((y_q + XW'(32768)) >>> 16);
        state_d = ST_ADD;
      end
      ST_ADD, ST_HOLD: begin
        if (!out_valid_q || out_pop_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d  = ST_HOLD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    iter_q <= iter_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) |-> (iter_q <= LAST)) else $error("cordic iteration overrun");
  a_mul_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> $past(job_pop_o)) else $error("multiply without job");
  a_load_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_ADD || state_q == ST_HOLD)) else $error("stray result load");
`endif

endmodule

### rtl/lidar_scan_to_world_points.sv
// Lidar scan to world points. Front end accepts one sample beat per cycle into a
// two-job queue while the queue is not full; the back end works one point at a time
// in steps (pop, multiply, CORDIC_STAGES iterations of one shared stage, round,
// offset) and takes no new job until the point is loaded into the result register.
// Samples that give no point pass at one per cycle while the queue has room.
// Asynchronous active-low reset clears config to defaults, scan state and queues.
`timescale 1ns / 1ps
module lidar_scan_to_world_points import lstwp_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  pt_in_t      in_item_i,
  output logic        empty,
  input  logic        pop,
  output pt_out_t     out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lstwp_cfg_t cfg_q;
  logic       wr_en, take, job_push, job_full, job_valid, job_pop, out_valid;
  pt_job_t    job_in, job_head;
  reg_idx_e   ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_SCAN_START:   cfg_q.scan_start_angle <= pwdata[15:0];
        REG_ANGLE_STEP:   cfg_q.angle_step       <= pwdata[15:0];
        REG_RANGE_LOW:    cfg_q.range_low        <= pwdata[15:0];
        REG_RANGE_HIGH:   cfg_q.range_high       <= pwdata[15:0];
        REG_POSE_X:       cfg_q.pose_x           <= pwdata;
        REG_POSE_Y:       cfg_q.pose_y           <= pwdata;
        REG_POSE_HEADING: cfg_q.pose_heading     <= pwdata[15:0];
        REG_DECIMATION:   cfg_q.decimation       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SCAN_START:   prdata = {16'd0, cfg_q.scan_start_angle};
      REG_ANGLE_STEP:   prdata = {16'd0, cfg_q.angle_step};
      REG_RANGE_LOW:    prdata = {16'd0, cfg_q.range_low};
      REG_RANGE_HIGH:   prdata = {16'd0, cfg_q.range_high};
      REG_POSE_X:       prdata = cfg_q.pose_x;
      REG_POSE_Y:       prdata = cfg_q.pose_y;
      REG_POSE_HEADING: prdata = {16'd0, cfg_q.pose_heading};
      REG_DECIMATION:   prdata = {22'd0, cfg_q.decimation};
      default:          prdata = '0;
    endcase
  end

  assign full  = job_full;
  assign take  = push && !job_full;
  assign empty = !out_valid;

  lstwp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .take_i     (take),
    .item_i     (in_item_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  lstwp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  lstwp_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .out_o       (out_item_o),
    .out_pop_i   (pop && out_valid)
  );

endmodule
